FILE: design/srs_pkg.sv
// Shared constants, codes and control types for the ramp sequencer.
`default_nettype none
package srs_pkg;

	localparam int CntW = 32;
	localparam int AccW = 20;
	localparam int ModeW = 3;
	localparam int StW = 2;
	localparam int SigW = 3;

	// 1e18 in ns^2, numerator of the ramp length
	localparam int NumW = 60;
	localparam logic [NumW-1:0] NS2 = 60'd1000000000000000000;
	localparam logic [CntW-1:0] TINT_RESET = 32'd1000000;
	localparam logic [CntW-1:0] RUN_CRUISE = 32'd10;

	localparam logic [ModeW-1:0] MODE_MOVE_BY = 3'd0;
	localparam logic [ModeW-1:0] MODE_MOVE_TO = 3'd1;
	localparam logic [ModeW-1:0] MODE_RUN = 3'd2;
	localparam logic [ModeW-1:0] MODE_TICK = 3'd3;
	localparam logic [ModeW-1:0] MODE_SET_POS = 3'd4;

	localparam logic [StW-1:0] ST_OK = 2'd0;
	localparam logic [StW-1:0] ST_INVALID = 2'd1;
	localparam logic [StW-1:0] ST_DIR_REFUSED = 2'd2;

	localparam logic [SigW-1:0] SIG_NONE = 3'd0;
	localparam logic [SigW-1:0] SIG_START = 3'd1;
	localparam logic [SigW-1:0] SIG_CRUISE = 3'd2;
	localparam logic [SigW-1:0] SIG_DECEL = 3'd3;
	localparam logic [SigW-1:0] SIG_HALT = 3'd4;

	localparam logic [1:0] REG_ACCEL = 2'd0;
	localparam logic [1:0] REG_TINT = 2'd1;
	localparam logic [1:0] REG_DUAL = 2'd2;

	typedef struct packed {
		logic accept;
		logic ramp_start;
		logic ramp_sel;   // 0: cruise interval, 1: present interval
		logic cap_acc;
		logic cap_idx;
		logic exec;
	} srs_cmd_t;

	typedef struct packed {
		logic plan_req;
		logic ramp_done;
		logic out_free;
	} srs_sts_t;

endpackage
`default_nettype wire

FILE: design/srs_ramp.sv
// Ramp length unit: n = 1e18 / (2*a*t^2) by staged multiply and bit-serial divide.
`default_nettype none
module srs_ramp
	import srs_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [CntW-1:0] t,
	input  wire logic            up,
	input  wire logic [AccW-1:0] accel,
	output logic                 done,
	output logic [CntW-1:0]      result
);

	localparam logic [2:0] R_IDLE = 3'd0;
	localparam logic [2:0] R_SQ = 3'd1;
	localparam logic [2:0] R_PL = 3'd2;
	localparam logic [2:0] R_PH = 3'd3;
	localparam logic [2:0] R_SUM = 3'd4;
	localparam logic [2:0] R_CHK = 3'd5;
	localparam logic [2:0] R_DIV = 3'd6;
	localparam logic [2:0] R_FIN = 3'd7;

	localparam int A2W = AccW + 1;
	localparam int PW = CntW + A2W;
	localparam int DW = 2 * CntW + A2W;
	localparam int CntDivW = $clog2(NumW);
	localparam logic [CntDivW-1:0] DIV_LAST = CntDivW'(NumW - 1);

	logic [2:0]           ph_q;
	logic [CntW-1:0]      t_q;
	logic                 up_q;
	logic [2*CntW-1:0]    t2_q;
	logic [PW-1:0]        plo_q, phi_q;
	logic [DW-1:0]        d_q;
	logic [NumW-1:0]      rem_q, dvd_q, quo_q;
	logic [CntDivW-1:0]   cnt_q;
	logic                 done_q;
	logic [CntW-1:0]      res_q;

	logic [A2W-1:0]       a2;
	logic [NumW:0]        trial;
	logic [NumW:0]        qq;
	logic                 fit;

	assign a2 = {accel, 1'b0};
	assign trial = {rem_q, dvd_q[NumW-1]};
	assign fit = trial >= {1'b0, d_q[NumW-1:0]};
	assign qq = {1'b0, quo_q} + {{NumW{1'b0}}, (up_q && rem_q != '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= R_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				R_IDLE: if (start) ph_q <= R_SQ;
				R_SQ: ph_q <= R_PL;
				R_PL: ph_q <= R_PH;
				R_PH: ph_q <= R_SUM;
				R_SUM: ph_q <= R_CHK;
				R_CHK: begin
					if (d_q == '0 || d_q > {{(DW-NumW){1'b0}}, NS2}) begin
						done_q <= 1'b1;
						ph_q <= R_IDLE;
					end else begin
						ph_q <= R_DIV;
					end
				end
				R_DIV: if (cnt_q == DIV_LAST) ph_q <= R_FIN;
				R_FIN: begin
					done_q <= 1'b1;
					ph_q <= R_IDLE;
				end
				default: ph_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			R_IDLE: begin
				if (start) begin
					t_q <= t;
					up_q <= up;
				end
			end
			R_SQ: t2_q <= (2*CntW)'(t_q) * (2*CntW)'(t_q);
			R_PL: plo_q <= PW'(t2_q[CntW-1:0]) * PW'(a2);
			R_PH: phi_q <= PW'(t2_q[2*CntW-1:CntW]) * PW'(a2);
			R_SUM: d_q <= {phi_q, {CntW{1'b0}}} + {{CntW{1'b0}}, plo_q};
			R_CHK: begin
				if (d_q == '0) res_q <= '0;
				else res_q <= {{(CntW-1){1'b0}}, up_q};
				rem_q <= '0;
				dvd_q <= NS2;
				quo_q <= '0;
				cnt_q <= '0;
			end
			R_DIV: begin
				// one quotient bit a cycle
				if (fit) rem_q <= NumW'(trial - {1'b0, d_q[NumW-1:0]});
				else rem_q <= trial[NumW-1:0];
				quo_q <= {quo_q[NumW-2:0], fit};
				dvd_q <= {dvd_q[NumW-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			R_FIN: begin
				if (qq[NumW:CntW] != '0) res_q <= '1;
				else res_q <= qq[CntW-1:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

FILE: design/srs_dp.sv
// Datapath: configuration, item latch, plan arithmetic, motion state and result word.
`default_nettype none
module srs_dp
	import srs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire srs_cmd_t               cmd,
	output srs_sts_t                    sts,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_idx,
	input  wire logic [31:0]            cfg_wdata,
	output logic [31:0]                 cfg_rdata,
	input  wire logic [ModeW-1:0]       mode,
	input  wire logic signed [CntW-1:0] amount,
	input  wire logic                   run_direction,
	input  wire logic [CntW-1:0]        present_interval_ns,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [StW-1:0]              status,
	output logic                        step_level,
	output logic                        dir_level,
	output logic signed [CntW-1:0]      position_out,
	output logic                        completed,
	output logic [SigW-1:0]             ramp_signal,
	output logic                        moving,
	output logic [CntW-1:0]             plan_accel,
	output logic [CntW-1:0]             plan_cruise,
	output logic [CntW-1:0]             plan_decel,
	output logic [CntW-1:0]             ramp_index
);

	logic [AccW-1:0]  accel_q;
	logic [CntW-1:0]  tint_q;
	logic             dual_q;

	logic [ModeW-1:0] mode_q;
	logic [CntW-1:0]  amt_q, cur_q, s_q, acc_q, idx_q;
	logic             rd_q;

	logic [CntW-1:0]  ae_q, cc_q, dc_q, rp_q, sl_q, pos_q;
	logic             pin_q, dir_q, vel_q, run_q;

	logic             ov_q;

	logic             ramp_done;
	logic [CntW-1:0]  ramp_res;
	logic             a_nz, faster;
	logic [CntW:0]    dlt;
	logic [CntW-1:0]  s_in;

	// plan
	logic [CntW-1:0]  pl_acc, pl_dec, pl_cst, pl_idx, total, rem;
	logic [CntW:0]    need;
	logic             pl_fail, is_run;

	// next state
	logic [CntW-1:0]  n_ae, n_cc, n_dc, n_rp, n_sl, n_pos;
	logic             n_pin, n_dir, n_vel, n_run, n_done, want, step_en;
	logic [StW-1:0]   n_st;
	logic [SigW-1:0]  n_sig;

	assign a_nz = accel_q != '0;
	assign faster = (tint_q > cur_q) && cur_q != '0;

	srs_ramp u_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ramp_start),
		.t      (cmd.ramp_sel ? cur_q : tint_q),
		.up     (cmd.ramp_sel ? 1'b0 : !faster),
		.accel  (accel_q),
		.done   (ramp_done),
		.result (ramp_res)
	);

	// move-to delta, saturated to 32 bits
	assign dlt = {amount[CntW-1], amount} - {pos_q[CntW-1], pos_q};
	always_comb begin
		if (mode == MODE_MOVE_TO) begin
			if (dlt[CntW] != dlt[CntW-1])
				s_in = dlt[CntW] ? {1'b1, {(CntW-1){1'b0}}} : {1'b0, {(CntW-1){1'b1}}};
			else
				s_in = dlt[CntW-1:0];
		end else begin
			s_in = amount;
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ACCEL: cfg_rdata = {{(32-AccW){1'b0}}, accel_q};
			REG_TINT: cfg_rdata = tint_q;
			REG_DUAL: cfg_rdata = {31'b0, dual_q};
			default: cfg_rdata = '0;
		endcase
	end

	assign sts.plan_req = (mode_q inside {MODE_MOVE_BY, MODE_MOVE_TO, MODE_RUN}) &&
		tint_q != '0;
	assign sts.ramp_done = ramp_done;
	assign sts.out_free = !ov_q || !out_stall;

	always_comb begin
		is_run = mode_q == MODE_RUN;
		total = s_q[CntW-1] ? CntW'(0 - s_q) : s_q;
		pl_acc = acc_q;
		pl_dec = acc_q;
		pl_idx = idx_q;
		pl_cst = '0;
		pl_fail = 1'b0;
		need = '0;
		rem = '0;
		if (!is_run && a_nz) begin
			if (total == 32'd1) begin
				pl_acc = 32'd1;
				pl_dec = '0;
			end else if (faster) begin
				need = {1'b0, pl_dec} + ((idx_q > acc_q) ? {1'b0, idx_q - acc_q} : '0);
				if (need > {1'b0, total}) pl_fail = 1'b1;
				else pl_cst = total - need[CntW-1:0];
			end else begin
				need = {1'b0, pl_dec} + ((acc_q > idx_q) ? {1'b0, acc_q - idx_q} : '0);
				if (need <= {1'b0, total}) begin
					pl_cst = total - need[CntW-1:0];
				end else if (idx_q > total) begin
					pl_fail = 1'b1;
				end else begin
					// triangular profile
					rem = total - idx_q;
					pl_acc = idx_q + {1'b0, rem[CntW-1:1]};
					pl_dec = pl_acc;
					pl_cst = {{(CntW-1){1'b0}}, rem[0]};
				end
			end
		end else begin
			pl_cst = RUN_CRUISE;
		end
		if (faster) begin
			pl_idx = pl_acc;
			pl_acc = idx_q;
		end
	end

	always_comb begin
		n_ae = ae_q; n_cc = cc_q; n_dc = dc_q; n_rp = rp_q; n_sl = sl_q; n_pos = pos_q;
		n_pin = pin_q; n_dir = dir_q; n_vel = vel_q; n_run = run_q;
		n_done = 1'b0;
		n_st = ST_OK;
		n_sig = SIG_NONE;
		want = 1'b0;
		step_en = 1'b0;
		case (mode_q)
			MODE_MOVE_BY, MODE_MOVE_TO: begin
				n_pin = 1'b1;
				if (tint_q == '0 || pl_fail) begin
					n_st = ST_INVALID;
				end else begin
					n_ae = pl_acc; n_cc = pl_cst; n_dc = pl_dec; n_rp = pl_idx;
					n_vel = 1'b0;
					n_sl = s_q;
					if (s_q == '0) begin
						n_st = ST_INVALID;
					end else begin
						want = !s_q[CntW-1];
						if (dir_q == want || !run_q || !a_nz) begin
							n_dir = want;
							n_run = 1'b1;
							n_sig = SIG_START;
						end else begin
							n_st = ST_DIR_REFUSED;
						end
					end
				end
			end
			MODE_RUN: begin
				if (tint_q == '0) begin
					n_st = ST_INVALID;
				end else begin
					n_pin = 1'b1;
					n_ae = pl_acc; n_cc = pl_cst; n_dc = pl_dec; n_rp = pl_idx;
					n_vel = 1'b1;
					if (dir_q == rd_q || !run_q) begin
						n_dir = rd_q;
						n_run = 1'b1;
						n_sig = SIG_START;
					end else begin
						n_st = ST_DIR_REFUSED;
					end
				end
			end
			MODE_TICK: begin
				if (run_q) begin
					step_en = vel_q || sl_q != '0 || !pin_q;
					if (step_en) begin
						n_pin = !pin_q;
						if (!n_pin || dual_q) n_pos = dir_q ? pos_q + 1'b1 : pos_q - 1'b1;
						if ((n_pin || dual_q) && rp_q != '1) n_rp = rp_q + 1'b1;
						if (a_nz) begin
							if (n_rp == ae_q) n_sig = SIG_CRUISE;
							else if (!vel_q && {1'b0, n_rp} == {1'b0, ae_q} + {1'b0, cc_q})
								n_sig = SIG_DECEL;
						end
					end
					if (!vel_q) begin
						if (!n_pin || dual_q) begin
							if (sl_q[CntW-1]) n_sl = sl_q + 1'b1;
							else if (sl_q != '0) n_sl = sl_q - 1'b1;
						end
						// halt overrides any phase signal
						if ((n_pin || dual_q) && n_sl == '0) begin
							n_run = 1'b0;
							n_pin = 1'b1;
							n_done = 1'b1;
							n_sig = SIG_HALT;
						end
					end
				end
			end
			MODE_SET_POS: n_pos = amt_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= '0;
			tint_q <= TINT_RESET;
			dual_q <= 1'b0;
			ae_q <= '0; cc_q <= '0; dc_q <= '0; rp_q <= '0; sl_q <= '0; pos_q <= '0;
			pin_q <= 1'b1; dir_q <= 1'b0; vel_q <= 1'b0; run_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ACCEL: accel_q <= cfg_wdata[AccW-1:0];
					REG_TINT: tint_q <= cfg_wdata;
					REG_DUAL: dual_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				ae_q <= n_ae; cc_q <= n_cc; dc_q <= n_dc; rp_q <= n_rp;
				sl_q <= n_sl; pos_q <= n_pos;
				pin_q <= n_pin; dir_q <= n_dir; vel_q <= n_vel; run_q <= n_run;
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode;
			amt_q <= amount;
			rd_q <= run_direction;
			cur_q <= present_interval_ns;
			s_q <= s_in;
		end
		if (cmd.cap_acc) acc_q <= ramp_res;
		if (cmd.cap_idx) idx_q <= ramp_res;
		if (cmd.exec) begin
			status <= n_st;
			step_level <= !n_pin;
			dir_level <= n_dir;
			position_out <= n_pos;
			completed <= n_done;
			ramp_signal <= n_sig;
			moving <= n_run;
			plan_accel <= n_ae;
			plan_cruise <= n_cc;
			plan_decel <= n_dc;
			ramp_index <= n_rp;
		end
	end

	assign out_valid = ov_q;

endmodule
`default_nettype wire

FILE: design/srs_ctrl.sv
// Controller: sequences accept, the two ramp-length runs and the state update.
`default_nettype none
module srs_ctrl
	import srs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire srs_sts_t sts,
	output srs_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_RA_WT = 3'd2;
	localparam logic [2:0] S_RI_GO = 3'd3;
	localparam logic [2:0] S_RI_WT = 3'd4;
	localparam logic [2:0] S_EXEC = 3'd5;

	logic [2:0] state_q, state_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (sts.plan_req) begin
					cmd.ramp_start = 1'b1;
					state_d = S_RA_WT;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_RA_WT: begin
				if (sts.ramp_done) begin
					cmd.cap_acc = 1'b1;
					state_d = S_RI_GO;
				end
			end
			S_RI_GO: begin
				cmd.ramp_start = 1'b1;
				cmd.ramp_sel = 1'b1;
				state_d = S_RI_WT;
			end
			S_RI_WT: begin
				cmd.ramp_sel = 1'b1;
				if (sts.ramp_done) begin
					cmd.cap_idx = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result word can be loaded
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

FILE: design/stepper_trapezoid_ramp_sequencer_core.sv
// Top level of the trapezoidal stepper ramp sequencer.
`default_nettype none
// One word in, one result word out, one word in flight at a time. A tick,
// set-position or unused mode goes from accept through a load state
// straight to the state update. A move or run computes two ramp lengths in
// one shared unit (squaring, two partial products, sum, then a bit-serial
// divide). A zero acceleration, a zero present interval or a divisor above
// 1e18 ends a ramp run before the divide, and a zero cruise interval skips
// both runs. A finished result waits in the output register while the next
// word may be accepted. Configuration writes land at 0x0 accel_rate, 0x4
// target_interval_ns and 0x8 step_both_edges; the user must write them only
// while the block is idle, and the block itself does not enforce it.
module stepper_trapezoid_ramp_sequencer_core
	import srs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [3:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [ModeW-1:0]       mode,
	input  wire logic signed [CntW-1:0] amount,
	input  wire logic                   run_direction,
	input  wire logic [CntW-1:0]        present_interval_ns,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [StW-1:0]              status,
	output logic                        step_level,
	output logic                        dir_level,
	output logic signed [CntW-1:0]      position_out,
	output logic                        completed,
	output logic [SigW-1:0]             ramp_signal,
	output logic                        moving,
	output logic [CntW-1:0]             plan_accel,
	output logic [CntW-1:0]             plan_cruise,
	output logic [CntW-1:0]             plan_decel,
	output logic [CntW-1:0]             ramp_index
);

	srs_cmd_t cmd;
	srs_sts_t sts;
	logic     cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	srs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	srs_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_we              (cfg_we),
		.cfg_idx             (paddr[3:2]),
		.cfg_wdata           (pwdata),
		.cfg_rdata           (prdata),
		.mode                (mode),
		.amount              (amount),
		.run_direction       (run_direction),
		.present_interval_ns (present_interval_ns),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.step_level          (step_level),
		.dir_level           (dir_level),
		.position_out        (position_out),
		.completed           (completed),
		.ramp_signal         (ramp_signal),
		.moving              (moving),
		.plan_accel          (plan_accel),
		.plan_cruise         (plan_cruise),
		.plan_decel          (plan_decel),
		.ramp_index          (ramp_index)
	);

endmodule
`default_nettype wire

FILE: design/srs_chk.sv
// Port-level checker for the ramp sequencer, bound to the top level.
`default_nettype none
module srs_chk
	import srs_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic signed [CntW-1:0] position_out,
	input wire logic                   completed,
	input wire logic [SigW-1:0]        ramp_signal,
	input wire logic                   moving,
	input wire logic                   step_level
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting a word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position_out))
		else $error("stalled result word changed");

	a_halt_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ramp_signal == SIG_HALT |-> completed)
		else $error("halt signal without completion");

	a_done_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && completed |-> !moving && !step_level)
		else $error("completion while still moving or pin high");

endmodule

bind stepper_trapezoid_ramp_sequencer_core srs_chk u_srs_chk (.*);
`default_nettype wire
